### src/hvss_pkg.sv
// Shared types and constants for the haplotype Viterbi site scorer.
// No dependencies; used by the top level and the generic RAM.
`default_nettype none

package hvss_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SLOT_BITS   = $clog2(MAX_SAMPLES);
  localparam int SCORE_BITS  = 48;
  localparam int SUM_BITS    = SCORE_BITS + 2;
  localparam int COST_BITS   = 32;
  localparam int NODE_BITS   = 32;
  localparam int SITE_BITS   = 32;
  localparam int COUNT_BITS  = 11;
  localparam int INDEX_BITS  = 10;
  localparam int ALLELE_BITS = 2;

  // allele code bit that marks an unphased heterozygote
  localparam int UNPHASED_BIT = 1;

  localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RST = COUNT_BITS'(1024);

  typedef struct packed {
    logic [INDEX_BITS-1:0]  sample_index;
    logic [ALLELE_BITS-1:0] sample_allele;
    logic [ALLELE_BITS-1:0] target_allele;
    logic [COST_BITS-1:0]   recomb_cost;
    logic [COST_BITS-1:0]   stay_cost;
    logic [COST_BITS-1:0]   mismatch_cost;
    logic [COST_BITS-1:0]   match_cost;
  } hvss_in_t;

  typedef struct packed {
    logic                  branched;
    logic [NODE_BITS-1:0]  node_id;
    logic [NODE_BITS-1:0]  parent_node;
    logic [SITE_BITS-1:0]  site_number;
    logic [INDEX_BITS-1:0] sample_out;
    logic [SCORE_BITS-1:0] path_score;
    logic                  site_done;
    logic [INDEX_BITS-1:0] best_index;
    logic [SCORE_BITS-1:0] best_total;
  } hvss_out_t;

endpackage

`default_nettype wire

### src/hvss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on hvss_pkg for default sizes.
`default_nettype none

module hvss_ram #(
  parameter int WIDTH = hvss_pkg::SCORE_BITS,
  parameter int DEPTH = hvss_pkg::MAX_SAMPLES,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read returns the old word on a same-address write
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rd_data = rdata_r;

endmodule

`default_nettype wire

### src/haplotype_viterbi_site_scorer.sv
// Haplotype Viterbi site scorer: one forward copying step per item; uses hvss_pkg, hvss_ram.
// Throughput: 1 item per cycle when the output is not stalled; a site-start item (index 0) waits
// for the previous site's best to commit, and an item whose index is still in the 3 stages waits.
// Reset (synchronous, rst_n low): control clears, then a clearing pass over all 1024 entries
// writes both stores (score 0, node = index) with in_ready low.
`default_nettype none

module haplotype_viterbi_site_scorer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire hvss_pkg::hvss_in_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output hvss_pkg::hvss_out_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [hvss_pkg::COUNT_BITS-1:0]     cfg_wdata
);

  localparam int SB = hvss_pkg::SCORE_BITS;
  localparam int XB = hvss_pkg::SUM_BITS;
  localparam int CB = hvss_pkg::COST_BITS;
  localparam int NB = hvss_pkg::NODE_BITS;
  localparam int TB = hvss_pkg::SITE_BITS;
  localparam int IB = hvss_pkg::INDEX_BITS;
  localparam int AB = hvss_pkg::SLOT_BITS;
  localparam int KB = hvss_pkg::COUNT_BITS;
  localparam int UB = hvss_pkg::UNPHASED_BIT;

  // Saturate a widened sum to the score range.
  function automatic logic [SB-1:0] sat_score(input logic [XB-1:0] v);
    sat_score = (|v[XB-1:SB]) ? {SB{1'b1}} : v[SB-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Pipeline
  //   accept : item captured in stage 1, score store read at its index
  //   stage 1: copy penalty, score + stay, worst-case step cost
  //   stage 2: threshold (latched at site start), branch decision, new score
  //   stage 3: running best, node allocation, store write-back, result out
  // Read/write hazards on the score store are avoided by refusing an item
  // whose index matches one still in any stage; then every read sees all
  // earlier writes to that entry.
  // ---------------------------------------------------------------------------

  // clearing pass
  logic          clr_busy_r, clr_busy_nxt;
  logic [AB-1:0] clr_addr_r, clr_addr_nxt;

  // configuration
  logic [KB-1:0] sample_count_r;

  // stage registers
  logic               s1_v_r;
  hvss_pkg::hvss_in_t s1_d_r;

  logic          s2_v_r;
  logic [IB-1:0] s2_sidx_r;
  logic          s2_first_r;
  logic [CB-1:0] s2_copy_r;
  logic [XB-1:0] s2_cs_r;
  logic [CB-1:0] s2_rho_r;
  logic [CB:0]   s2_msum_r;

  logic          s3_v_r;
  logic [IB-1:0] s3_sidx_r;
  logic          s3_first_r;
  logic [SB-1:0] s3_t_r;
  logic          s3_branch_r;
  logic [SB-1:0] s3_score_r;
  logic [SB-1:0] s3_rb_r;
  logic [IB-1:0] s3_ri_r;

  logic                out_v_r;
  hvss_pkg::hvss_out_t out_d_r, out_d_nxt;

  // site state
  logic [SB-1:0] threshold_r;
  logic [SB-1:0] run_best_r, run_best_nxt;
  logic [IB-1:0] run_idx_r, run_idx_nxt;
  logic [SB-1:0] best_score_r;
  logic [IB-1:0] best_idx_r;
  logic [NB-1:0] parent_r;
  logic [NB-1:0] next_node_r;
  logic [TB-1:0] site_r;

  // memory data
  logic [SB-1:0] score_rd;
  logic [NB-1:0] node_rd;

  // handshake and stage advance
  logic out_en, s3_adv, s3_free, s2_adv, s2_free, s1_first, s1_adv, s1_free;
  logic slot_hit, in_fire;

  always_comb begin
    out_en   = !out_v_r || out_ready;
    s3_adv   = s3_v_r && out_en;
    s3_free  = !s3_v_r || s3_adv;
    s2_adv   = s2_v_r && s3_free;
    s2_free  = !s2_v_r || s2_adv;
    s1_first = (s1_d_r.sample_index == '0);
    // site start needs stage 2 empty and stage 3 empty or advancing, so all earlier items commit first
    s1_adv   = s1_v_r && s2_free && (!s1_first || (!s2_v_r && s3_free));
    s1_free  = !s1_v_r || s1_adv;
    slot_hit = (s1_v_r && (s1_d_r.sample_index == in_data.sample_index)) ||
               (s2_v_r && (s2_sidx_r == in_data.sample_index)) ||
               (s3_v_r && (s3_sidx_r == in_data.sample_index));
    in_ready = !clr_busy_r && s1_free && !slot_hit;
    in_fire  = in_valid && in_ready;
  end

  // ---------------------------------------------------------------------------
  // Stage 1
  // ---------------------------------------------------------------------------
  logic          s1_unph;
  logic [CB:0]   s1_mu_sum;
  logic [CB-1:0] s1_copy;
  logic [XB-1:0] s1_cs;
  logic [CB-1:0] s1_rmax, s1_mmax;
  logic [CB:0]   s1_msum;

  always_comb begin
    s1_unph   = s1_d_r.sample_allele[UB] | s1_d_r.target_allele[UB];
    s1_mu_sum = {1'b0, s1_d_r.mismatch_cost} + {1'b0, s1_d_r.match_cost};
    if (s1_unph) begin
      s1_copy = s1_mu_sum[CB:1];
    end else if (s1_d_r.sample_allele == s1_d_r.target_allele) begin
      s1_copy = s1_d_r.match_cost;
    end else begin
      s1_copy = s1_d_r.mismatch_cost;
    end
    s1_cs   = XB'(score_rd) + XB'(s1_d_r.stay_cost);
    s1_rmax = (s1_d_r.recomb_cost > s1_d_r.stay_cost) ? s1_d_r.recomb_cost
                                                      : s1_d_r.stay_cost;
    s1_mmax = (s1_d_r.mismatch_cost > s1_d_r.match_cost) ? s1_d_r.mismatch_cost
                                                         : s1_d_r.match_cost;
    s1_msum = {1'b0, s1_rmax} + {1'b0, s1_mmax};
  end

  // ---------------------------------------------------------------------------
  // Stage 2
  // ---------------------------------------------------------------------------
  logic [SB-1:0] s2_t_prev, s2_t, s2_ts, s2_cps, s2_cs_sat, s2_score, s2_rb;
  logic          s2_branch;

  always_comb begin
    // threshold of the latest earlier item
    s2_t_prev = s3_v_r ? s3_t_r : threshold_r;
    s2_cs_sat = sat_score(s2_cs_r);
    s2_cps    = sat_score(s2_cs_r + XB'(s2_copy_r));
    if (s2_first_r) begin
      s2_t  = sat_score(XB'(best_score_r) + XB'(s2_rho_r));
      s2_ts = sat_score(XB'(best_score_r) + XB'(s2_rho_r) + XB'(s2_copy_r));
    end else begin
      s2_t  = s2_t_prev;
      s2_ts = sat_score(XB'(s2_t_prev) + XB'(s2_copy_r));
    end
    s2_branch = (s2_cs_sat > s2_t);
    s2_score  = s2_branch ? s2_ts : s2_cps;
    s2_rb     = sat_score(XB'(best_score_r) + XB'(s2_msum_r));
  end

  // ---------------------------------------------------------------------------
  // Stage 3
  // ---------------------------------------------------------------------------
  logic [SB-1:0] s3_r_src;
  logic [IB-1:0] s3_i_src;
  logic [NB-1:0] s3_parent;
  logic          s3_done;

  always_comb begin
    s3_r_src  = s3_first_r ? s3_rb_r : run_best_r;
    s3_i_src  = s3_first_r ? s3_ri_r : run_idx_r;
    // node read was issued as the site-start item entered this stage
    s3_parent = s3_first_r ? node_rd : parent_r;
    s3_done   = ((KB'(s3_sidx_r) + KB'(1)) == sample_count_r);
    if (s3_score_r < s3_r_src) begin
      run_best_nxt = s3_score_r;
      run_idx_nxt  = s3_sidx_r;
    end else begin
      run_best_nxt = s3_r_src;
      run_idx_nxt  = s3_i_src;
    end

    out_d_nxt.branched    = s3_branch_r;
    out_d_nxt.node_id     = s3_branch_r ? next_node_r : '0;
    out_d_nxt.parent_node = s3_branch_r ? s3_parent : '0;
    out_d_nxt.site_number = site_r;
    out_d_nxt.sample_out  = s3_sidx_r;
    out_d_nxt.path_score  = s3_score_r;
    out_d_nxt.site_done   = s3_done;
    out_d_nxt.best_index  = s3_done ? run_idx_nxt : '0;
    out_d_nxt.best_total  = s3_done ? run_best_nxt : '0;
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AB'(1);
      if (clr_addr_r == AB'(hvss_pkg::MAX_SAMPLES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r     <= 1'b1;
      clr_addr_r     <= '0;
      sample_count_r <= hvss_pkg::SAMPLE_COUNT_RST;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      s3_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      threshold_r    <= '0;
      run_best_r     <= '0;
      run_idx_r      <= '0;
      best_score_r   <= '0;
      best_idx_r     <= '0;
      parent_r       <= '0;
      next_node_r    <= NB'(hvss_pkg::MAX_SAMPLES);
      site_r         <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (cfg_we) begin
        sample_count_r <= cfg_wdata;
      end
      if (s1_free) begin
        s1_v_r <= in_fire;
      end
      if (s2_free) begin
        s2_v_r <= s1_adv;
      end
      if (s3_free) begin
        s3_v_r <= s2_adv;
      end
      if (out_en) begin
        out_v_r <= s3_adv;
      end
      if (s3_adv) begin
        threshold_r <= s3_t_r;
        run_best_r  <= run_best_nxt;
        run_idx_r   <= run_idx_nxt;
        if (s3_first_r) begin
          parent_r <= node_rd;
        end
        if (s3_branch_r) begin
          next_node_r <= next_node_r + NB'(1);
        end
        if (s3_done) begin
          best_score_r <= run_best_nxt;
          best_idx_r   <= run_idx_nxt;
          site_r       <= site_r + TB'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_d_r <= in_data;
    end
    if (s1_adv) begin
      s2_sidx_r  <= s1_d_r.sample_index;
      s2_first_r <= s1_first;
      s2_copy_r  <= s1_copy;
      s2_cs_r    <= s1_cs;
      s2_rho_r   <= s1_d_r.recomb_cost;
      s2_msum_r  <= s1_msum;
    end
    if (s2_adv) begin
      s3_sidx_r   <= s2_sidx_r;
      s3_first_r  <= s2_first_r;
      s3_t_r      <= s2_t;
      s3_branch_r <= s2_branch;
      s3_score_r  <= s2_score;
      s3_rb_r     <= s2_rb;
      s3_ri_r     <= best_idx_r;
    end
    if (s3_adv) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic          score_we;
  logic [AB-1:0] score_waddr;
  logic [SB-1:0] score_wdata;
  logic          node_we, node_re;
  logic [AB-1:0] node_waddr;
  logic [NB-1:0] node_wdata;

  always_comb begin
    score_we    = clr_busy_r || s3_adv;
    score_waddr = clr_busy_r ? clr_addr_r : AB'(s3_sidx_r);
    score_wdata = clr_busy_r ? '0 : s3_score_r;
    node_we     = clr_busy_r || (s3_adv && s3_branch_r);
    node_waddr  = clr_busy_r ? clr_addr_r : AB'(s3_sidx_r);
    node_wdata  = clr_busy_r ? NB'(clr_addr_r) : next_node_r;
    // parent lookup as the site-start item moves into stage 3
    node_re     = s2_adv && s2_first_r;
  end

  hvss_ram #(
    .WIDTH (SB),
    .DEPTH (hvss_pkg::MAX_SAMPLES)
  ) u_score_ram (
    .clk     (clk),
    .we      (score_we),
    .waddr   (score_waddr),
    .wdata   (score_wdata),
    .re      (in_fire),
    .raddr   (AB'(in_data.sample_index)),
    .rd_data (score_rd)
  );

  hvss_ram #(
    .WIDTH (NB),
    .DEPTH (hvss_pkg::MAX_SAMPLES)
  ) u_node_ram (
    .clk     (clk),
    .we      (node_we),
    .waddr   (node_waddr),
    .wdata   (node_wdata),
    .re      (node_re),
    .raddr   (AB'(best_idx_r)),
    .rd_data (node_rd)
  );

endmodule

`default_nettype wire
